// ----- rtl/core/ccpe_pkg.sv -----
// ----------------------------------------------------------------------------
// ccpe_pkg
// Shared types and constants for the contained circle packing engine.
// ----------------------------------------------------------------------------
package ccpe_pkg;

  localparam int MAX_CIRCLES = 256;
  localparam int IDX_W = $clog2(MAX_CIRCLES);
  localparam int CNT_W = $clog2(MAX_CIRCLES + 1);

  localparam int COORD_W = 14;
  localparam int RAD_W   = 13;
  localparam int GAP_W   = 10;
  localparam int OUTC_W  = 9;
  localparam int DIFF_W  = 15;
  localparam int SQ_W    = 32;

  // Config register indexes
  localparam logic [2:0] REG_CENTRE_X  = 3'd0;
  localparam logic [2:0] REG_CENTRE_Y  = 3'd1;
  localparam logic [2:0] REG_BOUNDARY  = 3'd2;
  localparam logic [2:0] REG_START_RAD = 3'd3;
  localparam logic [2:0] REG_PLACE_GAP = 3'd4;
  localparam logic [2:0] REG_GROW_GAP  = 3'd5;
  localparam logic [2:0] REG_GROW_STEP = 3'd6;

  localparam logic FUNC_PLACE = 1'b0;
  localparam logic FUNC_GROW  = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] centre_x;
    logic [COORD_W-1:0] centre_y;
    logic [RAD_W-1:0]   boundary_radius;
    logic [RAD_W-1:0]   start_radius;
    logic [GAP_W-1:0]   place_gap;
    logic [GAP_W-1:0]   grow_gap;
    logic [GAP_W-1:0]   grow_step;
  } cfg_t;

endpackage

// ----- rtl/core/ccpe_if.sv -----
// ----------------------------------------------------------------------------
// ccpe channel interfaces
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------
interface ccpe_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [13:0] cand_x;
  logic [13:0] cand_y;
  modport source (output valid, func, cand_x, cand_y, input ready);
  modport sink   (input valid, func, cand_x, cand_y, output ready);
endinterface

interface ccpe_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic       table_full;
  logic [8:0] stored_count;
  logic [8:0] growing_count;
  modport source (output valid, accepted, table_full, stored_count, growing_count,
                  input ready);
  modport sink   (input valid, accepted, table_full, stored_count, growing_count,
                  output ready);
endinterface

interface ccpe_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [13:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/ccpe_cfg.sv -----
// ----------------------------------------------------------------------------
// ccpe_cfg
// Configuration register file, written over the configuration channel.
// ----------------------------------------------------------------------------
module ccpe_cfg
  import ccpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ccpe_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.centre_x        <= 14'd6400;
      regs.centre_y        <= 14'd6400;
      regs.boundary_radius <= 13'd4080;
      regs.start_radius    <= 13'd80;
      regs.place_gap       <= 10'd32;
      regs.grow_gap        <= 10'd16;
      regs.grow_step       <= 10'd16;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CENTRE_X:  regs.centre_x        <= cfg.data;
        REG_CENTRE_Y:  regs.centre_y        <= cfg.data;
        REG_BOUNDARY:  regs.boundary_radius <= cfg.data[RAD_W-1:0];
        REG_START_RAD: regs.start_radius    <= cfg.data[RAD_W-1:0];
        REG_PLACE_GAP: regs.place_gap       <= cfg.data[GAP_W-1:0];
        REG_GROW_GAP:  regs.grow_gap        <= cfg.data[GAP_W-1:0];
        REG_GROW_STEP: regs.grow_step       <= cfg.data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/ccpe_dist.sv -----
// ----------------------------------------------------------------------------
// ccpe_dist
// Shared distance unit: one pipelined check of squared distance against a
// squared reach per cycle. Two register stages: squares, then sum and compare.
// ----------------------------------------------------------------------------
module ccpe_dist
  import ccpe_pkg::*;
(
  input  logic               clk,
  input  logic [COORD_W-1:0] ax,
  input  logic [COORD_W-1:0] ay,
  input  logic [COORD_W-1:0] bx,
  input  logic [COORD_W-1:0] by,
  input  logic [DIFF_W-1:0]  reach,
  input  logic               le_mode,
  output logic               hit
);

  logic [COORD_W-1:0] dx, dy;
  logic [2*COORD_W-1:0] sqx, sqy;
  logic [2*DIFF_W-1:0]  sqr;
  logic                 le_q;
  logic [SQ_W-1:0]      sum;

  assign dx = (ax > bx) ? ax - bx : bx - ax;
  assign dy = (ay > by) ? ay - by : by - ay;

  // Stage 1: the three squares
  always_ff @(posedge clk) begin
    sqx  <= dx * dx;
    sqy  <= dy * dy;
    sqr  <= reach * reach;
    le_q <= le_mode;
  end

  assign sum = {{(SQ_W-2*COORD_W){1'b0}}, sqx} + {{(SQ_W-2*COORD_W){1'b0}}, sqy};

  // Stage 2: compare (le_mode: inside test, else overlap test)
  always_ff @(posedge clk) begin
    hit <= le_q ? (sum <= {{(SQ_W-2*DIFF_W){1'b0}}, sqr})
                : (sum <  {{(SQ_W-2*DIFF_W){1'b0}}, sqr});
  end

endmodule

// ----- rtl/core/ccpe_ctrl.sv -----
// ----------------------------------------------------------------------------
// ccpe_ctrl
// Sequencer: holds the circle table and walks it through the shared distance
// unit for place and grow items.
// ----------------------------------------------------------------------------
module ccpe_ctrl
  import ccpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       regs,
  ccpe_in_if.sink    in_ch,
  ccpe_out_if.source out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_BND, S_BWAIT, S_SCAN, S_DRAIN, S_DECIDE,
    S_GNEXT, S_GREAD, S_GLOAD, S_COUNT, S_DONE
  } state_t;

  state_t state;

  // Circle table
  logic [COORD_W-1:0] mem_x [MAX_CIRCLES];
  logic [COORD_W-1:0] mem_y [MAX_CIRCLES];
  logic [RAD_W-1:0]   mem_r [MAX_CIRCLES];
  logic               mem_g [MAX_CIRCLES];

  logic [CNT_W-1:0] count;
  logic             grow_mode;
  logic [COORD_W-1:0] px, py;
  logic [RAD_W:0]   pr;          // trial radius, may reach 14 bits
  logic [CNT_W-1:0] gi;          // circle being grown
  logic [CNT_W-1:0] k;           // scan index
  logic [1:0]       infl;        // drain counter for checks in flight
  logic             blocked;
  logic [CNT_W-1:0] gcount;

  // Registered table read
  logic [COORD_W-1:0] rd_x, rd_y;
  logic [RAD_W-1:0]   rd_r;
  logic               rd_g;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_vld, rd_skip;

  logic [COORD_W-1:0] u_bx, u_by;
  logic [DIFF_W-1:0]  u_reach;
  logic               u_le, u_hit;
  logic               v1, v2, le1, le2;

  logic [IDX_W-1:0] wr_addr;

  always_ff @(posedge clk) begin
    rd_x <= mem_x[rd_addr];
    rd_y <= mem_y[rd_addr];
    rd_r <= mem_r[rd_addr];
    rd_g <= mem_g[rd_addr];
  end

  // Distance unit operand select
  always_comb begin
    u_bx = rd_x;
    u_by = rd_y;
    u_le = 1'b0;
    u_reach = DIFF_W'(pr) + DIFF_W'(rd_r) +
              DIFF_W'(grow_mode ? regs.grow_gap : regs.place_gap);
    if (state == S_BND) begin
      u_bx = regs.centre_x;
      u_by = regs.centre_y;
      u_le = 1'b1;
      u_reach = DIFF_W'(regs.boundary_radius) - DIFF_W'(pr);
    end
  end

  ccpe_dist u_dist (
    .clk(clk), .ax(px), .ay(py), .bx(u_bx), .by(u_by),
    .reach(u_reach), .le_mode(u_le), .hit(u_hit)
  );

  assign in_ch.ready = (state == S_IDLE);
  assign wr_addr = grow_mode ? gi[IDX_W-1:0] : count[IDX_W-1:0];

  // Hold the grown circle's address until its entry is loaded
  always_comb begin
    rd_addr = k[IDX_W-1:0];
    if (state == S_GNEXT || state == S_GREAD) rd_addr = gi[IDX_W-1:0];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_ch.valid <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= 1'b0;
      v1 <= rd_vld && !rd_skip;
      le1 <= 1'b0;
      v2 <= v1;
      le2 <= le1;
      if (v2 && !le2 && u_hit) blocked <= 1'b1;
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            grow_mode <= in_ch.func;
            px <= in_ch.cand_x;
            py <= in_ch.cand_y;
            pr <= {1'b0, regs.start_radius};
            blocked <= 1'b0;
            out_ch.accepted <= 1'b0;
            out_ch.table_full <= 1'b0;
            gi <= '0;
            if (in_ch.func == FUNC_GROW) state <= S_GNEXT;
            else if (count >= CNT_W'(MAX_CIRCLES)) begin
              out_ch.table_full <= 1'b1;
              state <= S_COUNT;
            end else state <= S_BND;
            k <= '0;
            gcount <= '0;
          end
        end
        S_BND: begin
          // boundary check issue; radius above boundary is blocked outright
          if (pr > {1'b0, regs.boundary_radius}) blocked <= 1'b1;
          v1 <= 1'b1;
          le1 <= 1'b1;
          infl <= 2'd0;
          state <= S_BWAIT;
        end
        S_BWAIT: begin
          if (v2 && le2) begin
            if (!u_hit) blocked <= 1'b1;
            k <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // one table read per cycle into the distance unit
          if (k < count) begin
            rd_vld <= 1'b1;
            rd_skip <= grow_mode && (k == gi);
            k <= k + 1'b1;
          end else begin
            infl <= 2'd0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          infl <= infl + 1'b1;
          if (infl == 2'd3) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (grow_mode) begin
            if (blocked) mem_g[wr_addr] <= 1'b0;
            else mem_r[wr_addr] <= pr[RAD_W-1:0];
            gi <= gi + 1'b1;
            state <= S_GNEXT;
          end else begin
            if (!blocked) begin
              mem_x[wr_addr] <= px;
              mem_y[wr_addr] <= py;
              mem_r[wr_addr] <= pr[RAD_W-1:0];
              mem_g[wr_addr] <= 1'b1;
              count <= count + 1'b1;
              out_ch.accepted <= 1'b1;
            end
            k <= '0;
            state <= S_COUNT;
          end
        end
        S_GNEXT: begin
          if (gi < count) state <= S_GREAD;
          else begin
            k <= '0;
            state <= S_COUNT;
          end
        end
        S_GREAD: state <= S_GLOAD;
        S_GLOAD: begin
          if (rd_g) begin
            px <= rd_x;
            py <= rd_y;
            pr <= {1'b0, rd_r} + (RAD_W+1)'(regs.grow_step);
            blocked <= 1'b0;
            state <= S_BND;
          end else begin
            gi <= gi + 1'b1;
            state <= S_GNEXT;
          end
        end
        S_COUNT: begin
          // tally growing flags, one table entry per cycle
          if (rd_vld && rd_g) gcount <= gcount + 1'b1;
          if (k < count) begin
            rd_vld <= 1'b1;
            rd_skip <= 1'b1;
            k <= k + 1'b1;
          end else if (!rd_vld) begin
            out_ch.valid <= 1'b1;
            out_ch.stored_count <= count[OUTC_W-1:0];
            out_ch.growing_count <= gcount[OUTC_W-1:0];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_cnt_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_CIRCLES)) else $error("count above capacity");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("ready while result pending");
  a_acc_full: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.accepted && out_ch.table_full))
    else $error("accepted and full together");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == $past(count) + 1'b1))
    else $error("count jumped");

endmodule

// ----- rtl/core/contained_circle_packing_engine_top.sv -----
// ----------------------------------------------------------------------------
// contained_circle_packing_engine_top
// Circle packing table with place and grow items.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  in_ch   | in  | func, cand_x, cand_y
//  out_ch  | out | accepted, table_full, stored_count, growing_count
//  cfg     | in  | index, data
//
// A place item checks the boundary, scans the stored circles for spacing and
// tallies the growing flags; a place on a full table is refused and only
// tallies. A grow pass checks each growing circle likewise, then tallies, all
// by one shared distance check per cycle. Not ready from acceptance until the
// result transaction completes. Reset is synchronous; the table is not cleared.
module contained_circle_packing_engine_top
  import ccpe_pkg::*;
(
  input logic        clk,
  input logic        rst,
  ccpe_in_if.sink    in_ch,
  ccpe_out_if.source out_ch,
  ccpe_cfg_if.sink   cfg
);

  cfg_t regs;

  ccpe_cfg u_cfg (.clk(clk), .rst(rst), .cfg(cfg), .regs(regs));

  ccpe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .regs(regs), .in_ch(in_ch), .out_ch(out_ch)
  );

endmodule

// ----- test/ccpe_tb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpe testbench channel interfaces
// The RTL interfaces are reused as they are; this file only holds a helper
// interface that records the random idle percentages shared by the drivers.
// ----------------------------------------------------------------------------
interface ccpe_idle_if;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
endinterface

// ----- test/contained_circle_packing_engine_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contained_circle_packing_engine_top_test
// Drives place and grow transactions into the circle packing engine, mirrors
// the circle table in a scoreboard and checks every result field. The
// configuration registers are changed between phases while the engine is idle.
// ----------------------------------------------------------------------------
module contained_circle_packing_engine_top_test;
  import ccpe_pkg::*;

  localparam int CYCLE_LIMIT = 5000000;

  typedef struct {
    logic       accepted;
    logic       table_full;
    logic [8:0] stored_count;
    logic [8:0] growing_count;
  } packing_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow circle table plus queue of pending results
  // --------------------------------------------------------------------------
  class packing_scoreboard;
    int unsigned     px[MAX_CIRCLES];
    int unsigned     py[MAX_CIRCLES];
    int unsigned     pr[MAX_CIRCLES];
    bit              pg[MAX_CIRCLES];
    int unsigned     n_circles;
    cfg_t            regs;
    packing_result_t pending[$];
    int unsigned     n_errors;
    int unsigned     n_checked, n_placed, n_full, n_grow;

    function void clear();
      n_circles = 0;
      regs.centre_x = 14'd6400;
      regs.centre_y = 14'd6400;
      regs.boundary_radius = 13'd4080;
      regs.start_radius = 13'd80;
      regs.place_gap = 10'd32;
      regs.grow_gap = 10'd16;
      regs.grow_step = 10'd16;
    endfunction

    function void write_reg(logic [2:0] idx, logic [13:0] d);
      case (idx)
        REG_CENTRE_X:  regs.centre_x = d;
        REG_CENTRE_Y:  regs.centre_y = d;
        REG_BOUNDARY:  regs.boundary_radius = d[12:0];
        REG_START_RAD: regs.start_radius = d[12:0];
        REG_PLACE_GAP: regs.place_gap = d[9:0];
        REG_GROW_GAP:  regs.grow_gap = d[9:0];
        REG_GROW_STEP: regs.grow_step = d[9:0];
        default: ;
      endcase
    endfunction

    function longint unsigned dist_sq(int unsigned ax, int unsigned ay,
                                      int unsigned bx, int unsigned by);
      longint unsigned dx, dy;
      dx = ax > bx ? ax - bx : bx - ax;
      dy = ay > by ? ay - by : by - ay;
      return dx * dx + dy * dy;
    endfunction

    function bit fits_boundary(int unsigned x, int unsigned y, int unsigned r);
      longint unsigned room;
      if (r > regs.boundary_radius) return 0;
      room = regs.boundary_radius - r;
      return dist_sq(x, y, regs.centre_x, regs.centre_y) <= room * room;
    endfunction

    function bit crowded(int unsigned x, int unsigned y, int unsigned r,
                         int unsigned gap, int unsigned skip);
      longint unsigned reach;
      for (int k = 0; k < n_circles; k++) begin
        if (k == skip) continue;
        reach = longint'(r) + pr[k] + gap;
        if (dist_sq(x, y, px[k], py[k]) < reach * reach) return 1;
      end
      return 0;
    endfunction

    // Note an accepted input transaction and queue its expected result
    function void note_item(logic func, logic [13:0] cx, logic [13:0] cy);
      packing_result_t res;
      int unsigned trial, ng;
      res.accepted = 0;
      res.table_full = 0;
      if (func == FUNC_PLACE) begin
        if (n_circles >= MAX_CIRCLES) begin
          res.table_full = 1;
          n_full++;
        end else if (fits_boundary(cx, cy, regs.start_radius) &&
                     !crowded(cx, cy, regs.start_radius, regs.place_gap,
                              MAX_CIRCLES)) begin
          px[n_circles] = cx;
          py[n_circles] = cy;
          pr[n_circles] = regs.start_radius;
          pg[n_circles] = 1;
          n_circles++;
          res.accepted = 1;
          n_placed++;
        end
      end else begin
        n_grow++;
        for (int k = 0; k < n_circles; k++) begin
          if (!pg[k]) continue;
          trial = pr[k] + regs.grow_step;
          if (!fits_boundary(px[k], py[k], trial) ||
              crowded(px[k], py[k], trial, regs.grow_gap, k))
            pg[k] = 0;
          else
            pr[k] = trial;
        end
      end
      ng = 0;
      for (int k = 0; k < n_circles; k++) ng += pg[k];
      res.stored_count = n_circles[8:0];
      res.growing_count = ng[8:0];
      pending = {pending, res};
    endfunction

    // Compare one result transaction with the oldest expectation
    function void check_result(packing_result_t got);
      packing_result_t want;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        n_errors++;
        return;
      end
      want = pending.pop_front();
      n_checked++;
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0d actual %0d", want.accepted, got.accepted);
        n_errors++;
      end
      if (got.table_full !== want.table_full) begin
        $error("table_full: expected %0d actual %0d", want.table_full,
               got.table_full);
        n_errors++;
      end
      if (got.stored_count !== want.stored_count) begin
        $error("stored_count: expected %0d actual %0d", want.stored_count,
               got.stored_count);
        n_errors++;
      end
      if (got.growing_count !== want.growing_count) begin
        $error("growing_count: expected %0d actual %0d", want.growing_count,
               got.growing_count);
        n_errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  int unsigned cycles = 0;

  ccpe_in_if   in_ch();
  ccpe_out_if  out_ch();
  ccpe_cfg_if  cfg();
  ccpe_idle_if idle();

  packing_scoreboard board = new();

  contained_circle_packing_engine_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.func = FUNC_PLACE;
    in_ch.cand_x = '0;
    in_ch.cand_y = '0;
    out_ch.ready = 0;
    cfg.valid = 0;
    cfg.index = REG_CENTRE_X;
    cfg.data = '0;
    idle.send_idle_pct = 0;
    idle.recv_idle_pct = 0;
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("contained_circle_packing_engine_top_test: errors");
      $finish;
    end
  end

  // Result side: sample at rising edge, random stall set at falling edge
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      board.check_result('{out_ch.accepted, out_ch.table_full,
                           out_ch.stored_count, out_ch.growing_count});
  end

  always @(negedge clk) begin
    out_ch.ready <= !rst && ($urandom_range(99) >= idle.recv_idle_pct);
  end

  // Send one item; note it in the scoreboard on acceptance
  task automatic send_item(logic func, logic [13:0] cx, logic [13:0] cy);
    while ($urandom_range(99) < idle.send_idle_pct) @(negedge clk);
    in_ch.valid = 1;
    in_ch.func = func;
    in_ch.cand_x = cx;
    in_ch.cand_y = cy;
    do @(posedge clk); while (!in_ch.ready);
    board.note_item(func, cx, cy);
    @(negedge clk);
    in_ch.valid = 0;
  endtask

  task automatic wait_drained();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [13:0] d);
    cfg.valid = 1;
    cfg.index = idx;
    cfg.data = d;
    do @(posedge clk); while (!cfg.ready);
    board.write_reg(idx, d);
    @(negedge clk);
    cfg.valid = 0;
  endtask

  // Candidate near the boundary centre, spread by the boundary radius
  task automatic send_place_near();
    int signed ox, oy, br;
    br = board.regs.boundary_radius + 1;
    ox = int'(board.regs.centre_x) + $signed($urandom_range(2 * br)) - br;
    oy = int'(board.regs.centre_y) + $signed($urandom_range(2 * br)) - br;
    if (ox < 0) ox = 0;
    if (oy < 0) oy = 0;
    if (ox > 16383) ox = 16383;
    if (oy > 16383) oy = 16383;
    send_item(FUNC_PLACE, ox[13:0], oy[13:0]);
  endtask

  task automatic random_phase(int unsigned n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: send_item(FUNC_PLACE, 14'($urandom), 14'($urandom));
        1, 2, 3: send_item(FUNC_GROW, 14'($urandom), 14'($urandom));
        default: send_place_near();
      endcase
    end
  endtask

  initial begin
    board.clear();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: field extremes at reset registers
    send_item(FUNC_GROW, 14'h3FFF, 14'h0000);
    send_item(FUNC_PLACE, 14'd0, 14'd0);
    send_item(FUNC_PLACE, 14'h3FFF, 14'h3FFF);
    send_item(FUNC_PLACE, 14'd6400, 14'd6400);
    send_item(FUNC_PLACE, 14'd6400, 14'd6400);
    send_item(FUNC_PLACE, 14'd6592, 14'd6400);
    send_item(FUNC_PLACE, 14'd6400, 14'd10400);
    send_item(FUNC_PLACE, 14'd6400, 14'd10401);
    repeat (4) send_item(FUNC_GROW, 14'h2AAA, 14'h1555);
    wait_drained();

    // Zero step with maximum grow gap, then zero gaps and start radius, then maximum step
    write_reg(REG_GROW_STEP, 14'd0);
    write_reg(REG_GROW_GAP, 14'd1023);
    send_item(FUNC_GROW, 14'd0, 14'd0);
    wait_drained();
    write_reg(REG_GROW_GAP, 14'd0);
    write_reg(REG_PLACE_GAP, 14'd0);
    write_reg(REG_START_RAD, 14'd0);
    write_reg(REG_BOUNDARY, 14'h1FFF);
    send_item(FUNC_PLACE, 14'd0, 14'd0);
    send_item(FUNC_PLACE, 14'd6400, 14'd6400);
    wait_drained();
    write_reg(REG_GROW_STEP, 14'd1023);
    repeat (3) send_item(FUNC_GROW, 14'd0, 14'd0);
    wait_drained();

    // Random phase 1: sender idles a little, receiver a lot
    write_reg(REG_CENTRE_X, 14'h3FFF);
    write_reg(REG_CENTRE_Y, 14'd0);
    write_reg(REG_BOUNDARY, 14'd3000);
    write_reg(REG_START_RAD, 14'd40);
    write_reg(REG_PLACE_GAP, 14'd1023);
    write_reg(REG_GROW_STEP, 14'd64);
    idle.send_idle_pct = 17;
    idle.recv_idle_pct = 62;
    random_phase(30);
    wait_drained();

    // Random phase 2: roles reversed, small circles
    write_reg(REG_CENTRE_X, 14'd6400);
    write_reg(REG_CENTRE_Y, 14'h3FFF);
    write_reg(REG_BOUNDARY, 14'h1FFF);
    write_reg(REG_START_RAD, 14'd1);
    write_reg(REG_PLACE_GAP, 14'd0);
    write_reg(REG_GROW_GAP, 14'd8);
    write_reg(REG_GROW_STEP, 14'd4);
    idle.send_idle_pct = 62;
    idle.recv_idle_pct = 17;
    random_phase(25);
    wait_drained();

    // Short row of places inside the boundary, then one grow pass
    idle.send_idle_pct = 0;
    idle.recv_idle_pct = 0;
    for (int i = 0; i < 10; i++)
      send_item(FUNC_PLACE, 14'(4000 + 500 * i), 14'(12000));
    send_item(FUNC_GROW, 14'd0, 14'd0);
    wait_drained();

    // Random phase 3: no idling, reset-like registers
    write_reg(REG_CENTRE_X, 14'd6400);
    write_reg(REG_CENTRE_Y, 14'd6400);
    write_reg(REG_BOUNDARY, 14'd4080);
    write_reg(REG_GROW_STEP, 14'd16);
    random_phase(15);
    wait_drained();

    $display("covered %0d results: %0d placed, %0d table-full refusals, %0d grow passes",
             board.n_checked, board.n_placed, board.n_full, board.n_grow);
    $display("final table holds %0d circles", board.n_circles);
    if (board.n_errors == 0 && board.pending.size() == 0)
      $display("contained_circle_packing_engine_top_test: clean");
    else
      $display("contained_circle_packing_engine_top_test: errors");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/ccpe_pkg.sv
rtl/core/ccpe_if.sv
rtl/core/ccpe_cfg.sv
rtl/core/ccpe_dist.sv
rtl/core/ccpe_ctrl.sv
rtl/core/contained_circle_packing_engine_top.sv
test/ccpe_tb_if.sv
test/contained_circle_packing_engine_top_test.sv
